### design/kfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfc_pkg
// Shared key codes, operator codes, echo characters and the command and
// status bundles between the calculator controller and datapath.
// ----------------------------------------------------------------------------
package kfc_pkg;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_ADD       = 4'd10;
    localparam logic [3:0] KEY_SUB       = 4'd11;
    localparam logic [3:0] KEY_MUL       = 4'd12;
    localparam logic [3:0] KEY_DIV       = 4'd13;
    localparam logic [3:0] KEY_EQ        = 4'd14;
    localparam logic [3:0] KEY_CLEAR     = 4'd15;
    localparam logic [3:0] KEY_OP_BASE   = 4'd9;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_EQ   = 3'd5;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_EQUAL = 8'h3D;
    localparam logic [7:0] CHAR_CLEAR = 8'h43;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam int RESULT_W = 16;

    typedef struct packed {
        logic load_key;
        logic iter_init;
        logic iter_step;
        logic commit;
    } kfc_cmd_t;

    typedef struct packed {
        logic needs_iter;
    } kfc_status_t;

    function automatic logic [7:0] op_char(input logic [2:0] op);
        logic [7:0] c;
        unique case (op)
            OP_ADD:  c = CHAR_PLUS;
            OP_SUB:  c = CHAR_MINUS;
            OP_MUL:  c = CHAR_STAR;
            OP_DIV:  c = CHAR_SLASH;
            OP_EQ:   c = CHAR_EQUAL;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

endpackage

### design/kfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfc_ctrl
// Controller: arming logic, key sequencing, iteration count for the shared
// multiply and divide unit, and the valid flag of the result register.
// ----------------------------------------------------------------------------
module kfc_ctrl #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 key_present,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  kfc_pkg::kfc_status_t status,
    output kfc_pkg::kfc_cmd_t    cmd
);
    import kfc_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_START  = 2'd1;
    localparam logic [1:0] ST_ITER   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             armed_reg, armed_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic             accept;
    logic             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_tready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!armed_reg) begin
                        armed_next = !key_present;
                    end else if (key_present) begin
                        armed_next   = 1'b0;
                        cmd.load_key = 1'b1;
                        state_next   = ST_START;
                    end
                end
            end
            ST_START: begin
                cmd.iter_init = 1'b1;
                cnt_next      = '0;
                state_next    = status.needs_iter ? ST_ITER : ST_COMMIT;
            end
            ST_ITER: begin
                cmd.iter_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_WIDTH - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            armed_reg <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

### design/kfc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfc_datapath
// Entry, accumulator and pending operator registers, the bit-serial
// multiply and restoring divide unit, and the result register.
// ----------------------------------------------------------------------------
module kfc_datapath #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [3:0]           key_code,
    input  kfc_pkg::kfc_cmd_t    cmd,
    output kfc_pkg::kfc_status_t status,
    output logic                 send_backspace,
    output logic [7:0]           echo_char,
    output logic                 show_result,
    output logic signed [15:0]   result_value,
    output logic                 clear_line,
    output logic                 divide_error
);
    import kfc_pkg::*;

    localparam int DW = DATA_WIDTH;

    logic [3:0]    key_reg;
    logic [DW-1:0] entry_reg, entry_next;
    logic [DW-1:0] acc_reg, acc_next;
    logic [2:0]    pend_reg, pend_next;
    logic [DW-1:0] work_p_reg, work_p_next;
    logic [DW-1:0] work_a_reg, work_a_next;
    logic [DW-1:0] work_b_reg, work_b_next;
    logic          neg_reg, neg_next;

    logic          bs_reg, bs_next;
    logic [7:0]    echo_reg, echo_next;
    logic          show_reg, show_next;
    logic          clr_reg, clr_next;
    logic          derr_reg, derr_next;
    logic [RESULT_W-1:0] res_next;
    logic [RESULT_W-1:0] res_reg;

    logic [DW-1:0] acc_mag, entry_mag;
    logic [DW:0]   div_shift, div_trial;
    logic          entry_zero;
    logic [2:0]    key_op;

    assign entry_zero = (entry_reg == '0);
    assign acc_mag    = acc_reg[DW-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign entry_mag  = entry_reg[DW-1] ? (~entry_reg + 1'b1) : entry_reg;
    assign div_shift  = {work_p_reg, work_a_reg[DW-1]};
    assign div_trial  = div_shift - {1'b0, work_b_reg};
    assign key_op     = 3'(key_reg - KEY_OP_BASE);

    assign status.needs_iter = (key_reg == KEY_EQ) &&
        ((pend_reg == OP_MUL) || ((pend_reg == OP_DIV) && !entry_zero));

    // Shared iterative unit.
    always_comb begin
        work_p_next = work_p_reg;
        work_a_next = work_a_reg;
        work_b_next = work_b_reg;
        neg_next    = neg_reg;
        if (cmd.iter_init) begin
            work_p_next = '0;
            if (pend_reg == OP_MUL) begin
                work_a_next = acc_reg;
                work_b_next = entry_reg;
            end else begin
                work_a_next = acc_mag;
                work_b_next = entry_mag;
            end
            neg_next = acc_reg[DW-1] ^ entry_reg[DW-1];
        end else if (cmd.iter_step) begin
            if (pend_reg == OP_MUL) begin
                if (work_b_reg[0]) begin
                    work_p_next = work_p_reg + work_a_reg;
                end
                work_a_next = work_a_reg << 1;
                work_b_next = work_b_reg >> 1;
            end else begin
                work_p_next = div_trial[DW] ? div_shift[DW-1:0] : div_trial[DW-1:0];
                work_a_next = {work_a_reg[DW-2:0], ~div_trial[DW]};
            end
        end
    end

    // Key decode and architectural state update.
    always_comb begin
        entry_next = entry_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        bs_next    = 1'b0;
        echo_next  = CHAR_NUL;
        show_next  = 1'b0;
        clr_next   = 1'b0;
        derr_next  = 1'b0;
        unique case (key_reg) inside
            [4'd0:KEY_DIGIT_MAX]: begin
                echo_next  = CHAR_ZERO + {4'd0, key_reg};
                entry_next = (entry_reg << 3) + (entry_reg << 1) + DW'(key_reg);
            end
            KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV: begin
                bs_next   = (pend_reg != OP_NONE) && (pend_reg != OP_EQ);
                echo_next = op_char(key_op);
                if (pend_reg == OP_NONE) begin
                    acc_next   = entry_reg;
                    entry_next = '0;
                end
                pend_next = key_op;
            end
            KEY_EQ: begin
                echo_next = CHAR_EQUAL;
                case (pend_reg)
                    OP_ADD: acc_next = acc_reg + entry_reg;
                    OP_SUB: acc_next = acc_reg - entry_reg;
                    OP_MUL: acc_next = work_p_reg;
                    OP_DIV: begin
                        if (entry_zero) begin
                            derr_next = 1'b1;
                        end else begin
                            acc_next = neg_reg ? (~work_a_reg + 1'b1) : work_a_reg;
                        end
                    end
                    default: acc_next = acc_reg;
                endcase
                show_next  = !derr_next;
                entry_next = '0;
                pend_next  = OP_EQ;
            end
            default: begin
                echo_next  = CHAR_CLEAR;
                entry_next = '0;
                acc_next   = '0;
                pend_next  = OP_NONE;
                clr_next   = 1'b1;
            end
        endcase
    end

    generate
        if (DW >= RESULT_W) begin : g_res_trunc
            assign res_next = acc_next[RESULT_W-1:0];
        end else begin : g_res_ext
            assign res_next = {{(RESULT_W - DW){1'b0}}, acc_next};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            acc_reg   <= '0;
            pend_reg  <= OP_NONE;
        end else if (cmd.commit) begin
            entry_reg <= entry_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg <= key_code;
        end
        work_p_reg <= work_p_next;
        work_a_reg <= work_a_next;
        work_b_reg <= work_b_next;
        neg_reg    <= neg_next;
        if (cmd.commit) begin
            bs_reg   <= bs_next;
            echo_reg <= echo_next;
            show_reg <= show_next;
            clr_reg  <= clr_next;
            derr_reg <= derr_next;
            res_reg  <= res_next;
        end
    end

    assign send_backspace = bs_reg;
    assign echo_char      = echo_reg;
    assign show_result    = show_reg;
    assign result_value   = signed'(res_reg);
    assign clear_line     = clr_reg;
    assign divide_error   = derr_reg;

endmodule

### design/keypad_four_function_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_four_function_calculator
// Four-function keypad calculator taking one scan sample per input transfer.
// ----------------------------------------------------------------------------
// Usage:
// Each input transfer on the s_ channel carries one keypad scan sample. A
// press counts only after an idle sample has armed the block; each counted
// press yields exactly one output transfer on the m_ channel, while idle
// samples and unarmed presses yield none.
// An idle or ignored sample is absorbed while in the idle state. A counted
// press passes through the start and commit states to the result register;
// '=' with a pending multiply or nonzero divide also runs, between them,
// through the shared bit-serial multiply/divide unit one bit per cycle.
// A new sample is taken as soon as the previous one has left the datapath,
// even while its result still waits in the output register.
// When the receiver stalls, the result holds on m_tdata and a further
// counted press waits in the datapath, holding s_tready low.
// Reset (aresetn low, synchronous) clears entry, accumulator and pending
// operator, disarms the keypad and drops m_tvalid.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator #(
    parameter int DATA_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] key_present, [4:1] key_code, [7:5] zero
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] send_backspace, [8:1] echo_char, [9] show_result,
    // [25:10] result_value, [26] clear_line, [27] divide_error, [31:28] zero
    output logic [31:0] m_tdata
);
    import kfc_pkg::*;

    kfc_cmd_t           cmd;
    kfc_status_t        status;
    logic               send_backspace;
    logic [7:0]         echo_char;
    logic               show_result;
    logic signed [15:0] result_value;
    logic               clear_line;
    logic               divide_error;

    kfc_ctrl #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .key_present(s_tdata[0]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .status     (status),
        .cmd        (cmd)
    );

    kfc_datapath #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .key_code      (s_tdata[4:1]),
        .cmd           (cmd),
        .status        (status),
        .send_backspace(send_backspace),
        .echo_char     (echo_char),
        .show_result   (show_result),
        .result_value  (result_value),
        .clear_line    (clear_line),
        .divide_error  (divide_error)
    );

    assign m_tdata = {4'd0, divide_error, clear_line, result_value, show_result,
                      echo_char, send_backspace};

endmodule

### bench/keypad_four_function_calculator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_checker
// Watches both stream channels of the keypad calculator. It tracks the
// arming, entry, accumulator and pending operator of the calculator for
// every accepted scan sample, queues the display update that each counted
// press must produce, and compares every output transfer field by field
// with the oldest queued update.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [0] key_present, [4:1] key_code, [7:5] zero
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [0] send_backspace, [8:1] echo_char, [9] show_result,
    // [25:10] result_value, [26] clear_line, [27] divide_error, [31:28] zero
    input  logic [31:0] m_tdata,
    output int          mismatch_count,
    output int          results_pending
);
    import kfc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                backspace;
        logic [7:0]          echo;
        logic                show;
        logic [RESULT_W-1:0] value;
        logic                clear;
        logic                div_error;
    } display_t;

    display_t            display_q[$];
    display_t            want;
    display_t            got;
    logic                keypad_armed = 1'b0;
    logic [RESULT_W-1:0] entry_val    = '0;
    logic [RESULT_W-1:0] accum        = '0;
    logic [2:0]          pend_op      = OP_NONE;
    int                  fails        = 0;

    function automatic logic [RESULT_W-1:0] signed_quotient(
        input logic [RESULT_W-1:0] dividend,
        input logic [RESULT_W-1:0] divisor
    );
        int a;
        int b;
        a = $signed(dividend);
        b = $signed(divisor);
        return RESULT_W'(a / b);
    endfunction

    task automatic predict_sample(input logic [7:0] sample);
        logic       present;
        logic [3:0] code;
        logic [2:0] op;
        display_t   upd;
        present = sample[0];
        code    = sample[4:1];
        upd     = '0;
        if (!keypad_armed) begin
            if (!present) begin
                keypad_armed = 1'b1;
            end
            return;
        end
        if (!present) begin
            return;
        end
        keypad_armed = 1'b0;
        if (code <= KEY_DIGIT_MAX) begin
            upd.echo  = CHAR_ZERO + 8'(code);
            entry_val = entry_val * RESULT_W'(10) + RESULT_W'(code);
        end else if (code <= KEY_DIV) begin
            op            = 3'(code - KEY_OP_BASE);
            upd.backspace = (pend_op != OP_NONE) && (pend_op != OP_EQ);
            case (op)
                OP_ADD:  upd.echo = CHAR_PLUS;
                OP_SUB:  upd.echo = CHAR_MINUS;
                OP_MUL:  upd.echo = CHAR_STAR;
                OP_DIV:  upd.echo = CHAR_SLASH;
                default: upd.echo = CHAR_NUL;
            endcase
            if (pend_op == OP_NONE) begin
                accum     = entry_val;
                entry_val = '0;
            end
            pend_op = op;
        end else if (code == KEY_EQ) begin
            upd.echo = CHAR_EQUAL;
            case (pend_op)
                OP_ADD: accum = accum + entry_val;
                OP_SUB: accum = accum - entry_val;
                OP_MUL: accum = accum * entry_val;
                OP_DIV: begin
                    if (entry_val == '0) begin
                        upd.div_error = 1'b1;
                    end else begin
                        accum = signed_quotient(accum, entry_val);
                    end
                end
                default: ;
            endcase
            upd.show  = !upd.div_error;
            entry_val = '0;
            pend_op   = OP_EQ;
        end else begin
            upd.echo  = CHAR_CLEAR;
            upd.clear = 1'b1;
            entry_val = '0;
            accum     = '0;
            pend_op   = OP_NONE;
        end
        upd.value = accum;
        display_q.push_back(upd);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            keypad_armed = 1'b0;
            entry_val    = '0;
            accum        = '0;
            pend_op      = OP_NONE;
            display_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.backspace = m_tdata[0];
                got.echo      = m_tdata[8:1];
                got.show      = m_tdata[9];
                got.value     = m_tdata[25:10];
                got.clear     = m_tdata[26];
                got.div_error = m_tdata[27];
                if (display_q.size() == 0) begin
                    if (fails < REPORT_LIMIT) begin
                        $display("Unexpected output transfer: m_tdata=%h", m_tdata);
                    end
                    fails++;
                end else begin
                    want = display_q.pop_front();
                    if (got.backspace !== want.backspace || got.echo !== want.echo ||
                        got.show !== want.show || got.value !== want.value ||
                        got.clear !== want.clear || got.div_error !== want.div_error) begin
                        if (fails < REPORT_LIMIT) begin
                            $display("Mismatch: expected bs=%b echo=%h show=%b value=%0d clr=%b derr=%b",
                                     want.backspace, want.echo, want.show,
                                     $signed(want.value), want.clear, want.div_error);
                            $display("          actual   bs=%b echo=%h show=%b value=%0d clr=%b derr=%b",
                                     got.backspace, got.echo, got.show,
                                     $signed(got.value), got.clear, got.div_error);
                        end
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_sample(s_tdata);
            end
        end
        mismatch_count  <= fails;
        results_pending <= display_q.size();
    end

endmodule

### bench/keypad_four_function_calculator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_four_function_calculator_tb
// Drives keypad scan samples into the calculator: a short directed sequence
// of the special key situations, then random key sequences that build and
// evaluate expressions, mixed with stray samples. Both channels stall at
// random, the receiver holds off once for a long stretch, and the checker
// module beside the block predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module keypad_four_function_calculator_tb;
    import kfc_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 500000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int mismatch_count;
    int results_pending;
    int tx_idle_pct   = IDLE_PCT;
    int rx_idle_pct   = IDLE_PCT;
    int hold_requests = 0;
    int items_sent    = 0;
    int cycle_count   = 0;

    keypad_four_function_calculator #(
        .DATA_WIDTH(RESULT_W)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    keypad_four_function_calculator_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .results_pending(results_pending)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : receiver
        int hold_served;
        hold_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_sample(input logic present, input logic [3:0] code);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, code, present};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic press_key(input logic [3:0] code);
        // A stray press may come ahead of the arming idle sample.
        if ($urandom_range(99) < 5) begin
            send_sample(1'b1, 4'($urandom_range(15)));
        end
        send_sample(1'b0, 4'($urandom_range(15)));
        if ($urandom_range(99) < 5) begin
            send_sample(1'b0, 4'($urandom_range(15)));
        end
        send_sample(1'b1, code);
        items_sent += 2;
    endtask

    task automatic enter_value(input int unsigned v);
        logic [3:0] digs [10];
        int         n;
        n = 0;
        do begin
            digs[n] = 4'(v % 10);
            v       = v / 10;
            n++;
        end while (v != 0);
        for (int i = n - 1; i >= 0; i--) begin
            press_key(digs[i]);
        end
    endtask

    task automatic enter_operand();
        int mode;
        mode = $urandom_range(99);
        if (mode < 40) begin
            enter_value($urandom_range(99));
        end else if (mode < 60) begin
            enter_value($urandom_range(65535));
        end else if (mode < 75) begin
            case ($urandom_range(6))
                0:       enter_value(0);
                1:       enter_value(1);
                2:       enter_value(9);
                3:       enter_value(32767);
                4:       enter_value(32768);
                5:       enter_value(65534);
                default: enter_value(65535);
            endcase
        end else if (mode < 90) begin
            // Long digit runs wrap the entry.
            repeat ($urandom_range(7, 5)) press_key(4'($urandom_range(9)));
        end
    endtask

    initial begin : stimulus
        int kind;
        int nops;
        bit stretch_done;
        bit pause_done;
        stretch_done = 1'b0;
        pause_done   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(1'b0, KEY_CLEAR);
        send_sample(1'b1, KEY_EQ);
        send_sample(1'b1, 4'd5);
        send_sample(1'b0, 4'd0);
        send_sample(1'b0, 4'd7);
        send_sample(1'b1, KEY_DIGIT_MAX);
        send_sample(1'b0, KEY_ADD);
        send_sample(1'b1, KEY_ADD);
        send_sample(1'b0, 4'd3);
        send_sample(1'b1, KEY_SUB);
        send_sample(1'b0, KEY_EQ);
        send_sample(1'b1, KEY_EQ);
        send_sample(1'b0, 4'd8);
        send_sample(1'b1, KEY_EQ);
        send_sample(1'b0, 4'd1);
        send_sample(1'b1, KEY_MUL);
        send_sample(1'b0, 4'd2);
        send_sample(1'b1, KEY_DIV);
        send_sample(1'b0, 4'd4);
        send_sample(1'b1, KEY_EQ);
        send_sample(1'b0, 4'd6);
        send_sample(1'b1, KEY_CLEAR);
        send_sample(1'b0, KEY_MUL);
        send_sample(1'b1, 4'd0);

        while (items_sent < RANDOM_ITEMS) begin
            if (!stretch_done && items_sent >= 300) begin
                stretch_done  = 1'b1;
                tx_idle_pct   = 0;
                rx_idle_pct   = 0;
                hold_requests <= hold_requests + 1;
            end
            if (stretch_done && items_sent >= 550) begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            if (!pause_done && items_sent >= 800) begin
                pause_done = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (results_pending != 0) @(posedge aclk);
            end
            kind = $urandom_range(99);
            if (kind < 8) begin
                // The most negative value divided by minus one wraps.
                press_key(KEY_CLEAR);
                enter_value(32768);
                press_key(KEY_DIV);
                enter_value(65535);
                press_key(KEY_EQ);
            end else if (kind < 20) begin
                repeat ($urandom_range(6, 1)) begin
                    send_sample(1'($urandom_range(1)), 4'($urandom_range(15)));
                end
            end else begin
                if ($urandom_range(3) == 0) begin
                    press_key(KEY_CLEAR);
                end
                enter_operand();
                nops = $urandom_range(3);
                repeat (nops) begin
                    press_key(4'($urandom_range(KEY_DIV, KEY_ADD)));
                    if ($urandom_range(4) == 0) begin
                        press_key(4'($urandom_range(KEY_DIV, KEY_ADD)));
                    end
                    enter_operand();
                end
                if ($urandom_range(9) != 0) begin
                    press_key(KEY_EQ);
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
